FILE: hdl/vcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_pkg: shared types and constants
// Widths, controller state and the command and status bundles that pass
// between the cosine similarity controller and its datapath.
// ----------------------------------------------------------------------------
package vcs_pkg;

    localparam int ACC_W    = 40;   // accumulator width
    localparam int DIG_W    = 20;   // digit width of the serial multiplier
    localparam int MUL_X_W  = 80;   // wide operand, four digits
    localparam int MUL_Y_W  = 40;   // narrow operand, two digits
    localparam int MUL_P_W  = 120;  // product width
    localparam int SIM_W    = 16;   // result width
    localparam int Q_W      = 16;   // width of the quotient search

    localparam logic [ACC_W-1:0] NORM_MAX = {ACC_W{1'b1}};

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_T,
        ST_MUL_PT,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MOP_P,
        MOP_D,
        MOP_T,
        MOP_PT
    } mul_op_t;

    typedef struct packed {
        logic    accept_en;
        logic    mul_start;
        mul_op_t mul_op;
        logic    out_load;
    } vcs_cmd_t;

    typedef struct packed {
        logic last_done;
        logic zero_norm;
        logic mul_done;
        logic search_last;
        logic out_free;
    } vcs_stat_t;

endpackage
`default_nettype wire

FILE: hdl/vcs_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_mul: digit-serial wide multiplier
// Multiplies an 80-bit operand by a 40-bit operand with one 20x20 multiplier,
// one digit pair per cycle, and accumulates the shifted partial products.
// ----------------------------------------------------------------------------
module vcs_mul
    import vcs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [MUL_X_W-1:0] x,
    input  wire logic [MUL_Y_W-1:0] y,
    output logic                    done,
    output logic [MUL_P_W-1:0]      prod
);

    logic [MUL_X_W-1:0] x_reg;
    logic [MUL_Y_W-1:0] y_reg;
    logic               run_reg;
    logic [2:0]         cnt_reg;
    logic               pv_reg;
    logic               plast_reg;
    logic [2*DIG_W-1:0] pp_reg;
    logic [2:0]         sh_reg;
    logic [MUL_P_W-1:0] acc_reg;
    logic               done_reg;

    logic [DIG_W-1:0]   xd;
    logic [DIG_W-1:0]   yd;

    assign xd = x_reg[DIG_W*cnt_reg[1:0] +: DIG_W];
    assign yd = y_reg[DIG_W*cnt_reg[2] +: DIG_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= pv_reg && plast_reg;
            pv_reg   <= run_reg;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg   <= cnt_reg + 3'd1;
                plast_reg <= (cnt_reg == 3'd7);
                if (cnt_reg == 3'd7) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg
                + (MUL_P_W'(pp_reg) << (7'(sh_reg) * 7'(DIG_W)));
        end
        pp_reg <= xd * yd;
        sh_reg <= 3'(cnt_reg[1:0]) + 3'(cnt_reg[2]);
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

FILE: hdl/vcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_ctrl: sequencing controller
// Steps through accumulation, the norm and dot products, the bitwise
// quotient search and the result hand-off.
// ----------------------------------------------------------------------------
module vcs_ctrl
    import vcs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire vcs_stat_t stat,
    output vcs_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        launch_reg, launch_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (stat.last_done) begin
                    state_next = stat.zero_norm ? ST_OUT : ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                if (stat.mul_done) state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                if (stat.mul_done) state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                if (stat.mul_done) state_next = ST_MUL_PT;
            end
            ST_MUL_PT: begin
                if (stat.mul_done) state_next = stat.search_last ? ST_OUT : ST_MUL_T;
            end
            ST_OUT: begin
                if (stat.out_free) state_next = ST_ACC;
            end
            default: state_next = ST_ACC;
        endcase
    end

    assign launch_next = (state_next != state_reg)
        && (state_next inside {ST_MUL_P, ST_MUL_D, ST_MUL_T, ST_MUL_PT});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACC;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    always_comb begin
        cmd.accept_en = (state_reg == ST_ACC);
        cmd.mul_start = launch_reg;
        cmd.out_load  = (state_reg == ST_OUT) && stat.out_free;
        case (state_reg)
            ST_MUL_D:  cmd.mul_op = MOP_D;
            ST_MUL_T:  cmd.mul_op = MOP_T;
            ST_MUL_PT: cmd.mul_op = MOP_PT;
            default:   cmd.mul_op = MOP_P;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/vcs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_dp: datapath
// Element products, saturating accumulators, search registers and the
// registered result stage.
// ----------------------------------------------------------------------------
module vcs_dp
    import vcs_pkg::*;
#(
    parameter int MAX_LENGTH   = 512,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire vcs_cmd_t                cmd,
    output vcs_stat_t                    stat,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [ELEMENT_BITS-1:0] a_element,
    input  wire logic [ELEMENT_BITS-1:0] b_element,
    input  wire logic                    last,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [SIM_W-1:0]             similarity,
    output logic                         zero_norm,
    output logic                         too_long
);

    localparam int PW    = 2 * ELEMENT_BITS;
    localparam int SUM_W = ((PW > ACC_W) ? PW : ACC_W) + 2;
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);

    localparam logic signed [SUM_W-1:0] DOT_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] DOT_MIN = -DOT_MAX - SUM_W'(1);

    logic                     accept;
    logic                     pend_reg;
    logic                     s1_valid_reg, s1_last_reg;
    logic signed [PW-1:0]     pab_reg;
    logic        [PW-1:0]     paa_reg, pbb_reg;
    logic                     last_done_reg;

    logic signed [ACC_W-1:0]  dot_reg;
    logic        [ACC_W-1:0]  na_reg, nb_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     ovf_reg;

    logic signed [SUM_W-1:0]  dot_sum;
    logic        [SUM_W-1:0]  na_sum, nb_sum;

    mul_op_t                  op_reg;
    logic [MUL_X_W-1:0]       p_reg;
    logic [MUL_P_W-1:0]       d_reg;
    logic [MUL_Y_W-1:0]       t2_reg;
    logic [Q_W-1:0]           m_reg;
    logic [3:0]               bidx_reg;
    logic [Q_W-1:0]           cand;
    logic [Q_W:0]             tval;

    logic                     neg;
    logic [ACC_W-1:0]         dmag;
    logic [MUL_X_W-1:0]       mx;
    logic [MUL_Y_W-1:0]       my;
    logic                     mdone;
    logic [MUL_P_W-1:0]       mprod;

    logic [Q_W-1:0]           qcap;
    logic [SIM_W-1:0]         sim_val;
    logic                     zn_now;

    logic                     ov_reg;
    logic [SIM_W-1:0]         sim_reg;
    logic                     zn_reg, tl_reg;

    assign in_ready = cmd.accept_en && !pend_reg;
    assign accept   = in_valid && in_ready;

    // Element products, one pair per cycle while the input is ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            last_done_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= accept;
            s1_last_reg   <= accept && last;
            last_done_reg <= s1_valid_reg && s1_last_reg;
            if (accept && last) begin
                pend_reg <= 1'b1;
            end else if (cmd.out_load) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pab_reg <= $signed(a_element) * $signed(b_element);
        paa_reg <= PW'($signed(a_element) * $signed(a_element));
        pbb_reg <= PW'($signed(b_element) * $signed(b_element));
    end

    assign dot_sum = SUM_W'(dot_reg) + SUM_W'(pab_reg);
    assign na_sum  = SUM_W'(na_reg) + SUM_W'(paa_reg);
    assign nb_sum  = SUM_W'(nb_reg) + SUM_W'(pbb_reg);

    // Saturating accumulators and pair counter.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (s1_valid_reg) begin
            if (dot_sum > DOT_MAX) begin
                dot_reg <= ACC_W'(DOT_MAX);
            end else if (dot_sum < DOT_MIN) begin
                dot_reg <= ACC_W'(DOT_MIN);
            end else begin
                dot_reg <= ACC_W'(dot_sum);
            end
            na_reg <= (na_sum > SUM_W'(NORM_MAX)) ? NORM_MAX : ACC_W'(na_sum);
            nb_reg <= (nb_sum > SUM_W'(NORM_MAX)) ? NORM_MAX : ACC_W'(nb_sum);
            if (cnt_reg >= CNT_W'(MAX_LENGTH)) begin
                ovf_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    assign neg    = dot_reg[ACC_W-1];
    assign dmag   = neg ? (ACC_W'(0) - dot_reg) : dot_reg;
    assign zn_now = (na_reg == '0) || (nb_reg == '0);

    assign cand = m_reg | (Q_W'(1) << bidx_reg);
    assign tval = {cand, 1'b0} - (Q_W+1)'(1);

    always_comb begin
        case (cmd.mul_op)
            MOP_P: begin
                mx = MUL_X_W'(na_reg);
                my = nb_reg;
            end
            MOP_D: begin
                mx = MUL_X_W'(dmag);
                my = dmag;
            end
            MOP_T: begin
                mx = MUL_X_W'(tval);
                my = MUL_Y_W'(tval);
            end
            default: begin
                mx = p_reg;
                my = t2_reg;
            end
        endcase
    end

    vcs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x       (mx),
        .y       (my),
        .done    (mdone),
        .prod    (mprod)
    );

    // Product capture and quotient search: one bit per product comparison, from the top bit down.
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            op_reg <= cmd.mul_op;
        end
        if (last_done_reg) begin
            m_reg    <= '0;
            bidx_reg <= 4'(Q_W - 1);
        end else if (mdone) begin
            case (op_reg)
                MOP_P:  p_reg  <= mprod[MUL_X_W-1:0];
                MOP_D:  d_reg  <= {mprod[MUL_P_W-33:0], 32'd0};
                MOP_T:  t2_reg <= mprod[MUL_Y_W-1:0];
                MOP_PT: begin
                    if (mprod <= d_reg) begin
                        m_reg <= cand;
                    end
                    bidx_reg <= bidx_reg - 4'd1;
                end
                default: ;
            endcase
        end
    end

    assign qcap = (m_reg > Q_W'(32768)) ? Q_W'(32768) : m_reg;

    always_comb begin
        if (zn_now) begin
            sim_val = '0;
        end else if (neg) begin
            sim_val = SIM_W'(0) - SIM_W'(qcap);
        end else begin
            sim_val = (qcap > Q_W'(32767)) ? SIM_W'(32767) : SIM_W'(qcap);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sim_reg <= sim_val;
            zn_reg  <= zn_now;
            tl_reg  <= ovf_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign similarity = sim_reg;
    assign zero_norm  = zn_reg;
    assign too_long   = tl_reg;

    assign stat.last_done   = last_done_reg;
    assign stat.zero_norm   = zn_now;
    assign stat.mul_done    = mdone;
    assign stat.search_last = (bidx_reg == 4'd0);
    assign stat.out_free    = !ov_reg || out_ready;

endmodule
`default_nettype wire

FILE: hdl/vector_cosine_similarity.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_cosine_similarity: streaming cosine similarity
// Accumulates dot product and squared norms of two vectors and reports their
// cosine similarity in signed Q1.15.
// ----------------------------------------------------------------------------
// Element pairs arrive on the s_ stream, one request per pair, and are taken
// at one pair per cycle while a vector is being accumulated; the dot product
// and both squared norms are kept in 40-bit saturating accumulators. The pair
// marked by s_tlast closes the vector. The block then stops taking requests
// and runs its final step on a single 20x20 digit-serial multiplier: the
// product of the norms, the square of the dot product, and a sixteen-step
// bitwise search for the quotient with two wide products per step. The
// result is then held in the output register and the next vector may
// start at once, even if the result has not yet been taken. A vector
// with a zero norm skips the search and reports similarity 0 with
// zero_norm set. A vector longer than MAX_LENGTH pairs is still
// accumulated but reports too_long. The similarity is rounded to nearest,
// with +1.0 saturated to 32767.
// ----------------------------------------------------------------------------
module vector_cosine_similarity
    import vcs_pkg::*;
#(
    parameter int MAX_LENGTH   = 512,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    // tdata fields from bit 0: a_element, b_element, zero fill to whole bytes
    input  wire logic [((2*ELEMENT_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    // tdata fields from bit 0: similarity
    output logic [SIM_W-1:0] m_tdata,
    // tuser fields from bit 0: zero_norm, too_long
    output logic [1:0]       m_tuser
);

    vcs_cmd_t  cmd;
    vcs_stat_t stat;
    logic      zn, tl;

    vcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    vcs_dp #(
        .MAX_LENGTH   (MAX_LENGTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .a_element  (s_tdata[ELEMENT_BITS-1:0]),
        .b_element  (s_tdata[2*ELEMENT_BITS-1:ELEMENT_BITS]),
        .last       (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .similarity (m_tdata),
        .zero_norm  (zn),
        .too_long   (tl)
    );

    assign m_tuser = {tl, zn};

endmodule
`default_nettype wire

FILE: hdl/vcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vcs_checker: port-level checks
// Watches the stream ports of the cosine similarity block.
// ----------------------------------------------------------------------------
module vcs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A result that waits is not withdrawn.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // A zero norm always reports similarity zero.
    a_zero_sim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("zero norm with nonzero similarity");

    // Taking the final pair closes input to the request right after it.
    a_last_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("request taken right after the final pair");

    // No result comes out of reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind vector_cosine_similarity vcs_checker u_vcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
